// ===== sv/imd_pkg.sv =====
// Package for the integer matrix determinant block.
// Types, constants and the command struct shared by the controller, datapath and top.
package imd_pkg;

    localparam int unsigned DET_W   = 64;
    localparam int unsigned ORDER_W = 4;

    // Register indexes on the configuration port
    localparam logic [0:0] REG_MATRIX_ORDER = 1'b0;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_INIT,
        ST_TERM,
        ST_MUL,
        ST_STORE,
        ST_OUT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic init;
        logic issue;
        logic accum;
        logic clr_acc;
        logic store;
    } t_cmd;

endpackage

// ===== sv/imd_if.sv =====
// Valid/ready channel interface for the determinant block.
// Depends on nothing; payload width set by parameter.
interface imd_if #(
    parameter int unsigned WIDTH = 8
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ===== sv/imd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
module imd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/imd_datapath.sv =====
// Datapath: matrix and subset-determinant memories, multiplier and accumulator.
// Depends on imd_pkg and imd_ram.
module imd_datapath #(
    parameter int unsigned MAX_ORDER     = 8,
    parameter int unsigned ELEMENT_WIDTH = 7
) (
    input  logic                                i_clk,
    input  imd_pkg::t_cmd                       i_cmd,
    input  logic                                i_mat_we,
    input  logic [$clog2(MAX_ORDER*MAX_ORDER)-1:0] i_mat_waddr,
    input  logic signed [ELEMENT_WIDTH-1:0]     i_mat_wdata,
    input  logic [$clog2(MAX_ORDER*MAX_ORDER)-1:0] i_mat_raddr,
    input  logic [MAX_ORDER-1:0]                i_sub_raddr,
    input  logic [MAX_ORDER-1:0]                i_sub_waddr,
    input  logic                                i_negate,
    output logic [imd_pkg::DET_W-1:0]           o_acc
);
    import imd_pkg::*;

    localparam int unsigned CELLS = MAX_ORDER * MAX_ORDER;
    localparam int unsigned SUBS  = 1 << MAX_ORDER;

    logic signed [ELEMENT_WIDTH-1:0] w_elem;
    logic [DET_W-1:0]               w_sub;
    logic [DET_W-1:0]               w_wdata;
    logic                           w_we;
    logic [DET_W-1:0]               r_prod;
    logic [DET_W-1:0]               r_acc;
    logic                           r_neg;
    logic                           r_neg_d;

    imd_ram #(.WIDTH(ELEMENT_WIDTH), .DEPTH(CELLS)) u_mat (
        .i_clk  (i_clk),
        .i_we   (i_mat_we),
        .i_waddr(i_mat_waddr),
        .i_wdata(i_mat_wdata),
        .i_raddr(i_mat_raddr),
        .o_rdata(w_elem)
    );

    // subset 0 is written with one at init, others with the finished sum
    assign w_we    = i_cmd.init | i_cmd.store;
    assign w_wdata = i_cmd.init ? DET_W'(1) : r_acc;

    imd_ram #(.WIDTH(DET_W), .DEPTH(SUBS)) u_sub (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(i_sub_waddr),
        .i_wdata(w_wdata),
        .i_raddr(i_sub_raddr),
        .o_rdata(w_sub)
    );

    // product of element and minor, wraps modulo 2^64; sign follows the term
    // through read and multiply stages
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_neg <= i_negate;
        end
        r_neg_d <= r_neg;
        r_prod  <= DET_W'($signed(w_sub) * w_elem);
        if (i_cmd.clr_acc) begin
            r_acc <= '0;
        end else if (i_cmd.accum) begin
            r_acc <= r_neg_d ? r_acc - r_prod : r_acc + r_prod;
        end
    end

    assign o_acc = r_acc;
endmodule

// ===== sv/imd_ctrl.sv =====
// Controller: load counting and walk over column subsets and their terms.
// Depends on imd_pkg.
module imd_ctrl #(
    parameter int unsigned MAX_ORDER = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic [imd_pkg::ORDER_W-1:0]            i_order,
    input  logic                                   i_in_valid,
    input  logic                                   i_in_last,
    output logic                                   o_in_ready,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output imd_pkg::t_cmd                          o_cmd,
    output logic                                   o_mat_we,
    output logic [$clog2(MAX_ORDER*MAX_ORDER)-1:0] o_mat_waddr,
    output logic [$clog2(MAX_ORDER*MAX_ORDER)-1:0] o_mat_raddr,
    output logic [MAX_ORDER-1:0]                   o_sub_raddr,
    output logic [MAX_ORDER-1:0]                   o_sub_waddr,
    output logic                                   o_negate
);
    import imd_pkg::*;

    localparam int unsigned CW = $clog2(MAX_ORDER*MAX_ORDER);
    localparam int unsigned NW = $clog2(MAX_ORDER + 1);
    localparam int unsigned IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int unsigned LW = CW + 1;

    t_state            r_state, n_state;
    logic [LW-1:0]     r_cnt;
    logic [MAX_ORDER-1:0] r_mask;
    logic [IW-1:0]     r_col;
    logic [NW-1:0]     r_pos;
    logic [NW-1:0]     r_rank;
    logic [1:0]        r_pipe;
    logic [NW-1:0]     w_n;
    logic [LW-1:0]     w_cells;
    logic [MAX_ORDER-1:0] w_full;
    logic              w_accept;
    logic              w_has;
    logic              w_col_end;

    // active order: zero reads as one, large values saturate
    always_comb begin
        if (i_order == '0) begin
            w_n = NW'(1);
        end else if (32'(i_order) > MAX_ORDER) begin
            w_n = NW'(MAX_ORDER);
        end else begin
            w_n = NW'(i_order);
        end
    end
    assign w_cells   = LW'(w_n) * LW'(w_n);
    assign w_full    = MAX_ORDER'((1 << w_n) - 1);
    assign w_accept  = i_in_valid && o_in_ready;
    assign w_has     = r_mask[r_col];
    assign w_col_end = (32'(r_col) == 32'(w_n) - 1);

    assign o_in_ready  = (r_state == ST_LOAD);
    assign o_out_valid = (r_state == ST_OUT);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD:  if (w_accept && i_in_last) n_state = ST_INIT;
            ST_INIT:  n_state = ST_TERM;
            ST_TERM:  if (w_col_end) n_state = ST_MUL;
            ST_MUL:   if (r_pipe == '0) n_state = ST_STORE;
            ST_STORE: n_state = (r_mask == w_full) ? ST_OUT : ST_TERM;
            ST_OUT:   if (i_out_ready) n_state = ST_LOAD;
            default:  n_state = ST_LOAD;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd         = '0;
        o_cmd.init    = (r_state == ST_INIT);
        o_cmd.issue   = (r_state == ST_TERM) && w_has;
        o_cmd.store   = (r_state == ST_STORE);
        o_cmd.clr_acc = (r_state == ST_INIT) || (r_state == ST_STORE);
        o_cmd.accum   = (r_pipe[1]);
        o_mat_we      = w_accept && (r_cnt < w_cells);
        o_mat_waddr   = r_cnt[CW-1:0];
        o_mat_raddr   = CW'((32'(r_rank) - 1) * 32'(w_n) + 32'(r_col));
        o_sub_raddr   = r_mask ^ MAX_ORDER'(1 << r_col);
        o_sub_waddr   = (r_state == ST_INIT) ? '0 : r_mask;
        o_negate      = r_rank[0] ^ r_pos[0] ^ 1'b1;
    end

    // control registers; r_pipe tracks terms in flight (read, multiply)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
            r_mask  <= '0;
            r_col   <= '0;
            r_pos   <= '0;
            r_rank  <= '0;
            r_pipe  <= '0;
        end else begin
            r_state <= n_state;
            r_pipe  <= {r_pipe[0], o_cmd.issue};
            if (w_accept && (r_cnt < w_cells)) begin
                r_cnt <= r_cnt + LW'(1);
            end
            case (r_state)
                ST_INIT: begin
                    r_mask <= MAX_ORDER'(1);
                    r_rank <= NW'(1);
                    r_col  <= '0;
                    r_pos  <= '0;
                end
                ST_TERM: begin
                    if (w_has) r_pos <= r_pos + NW'(1);
                    if (!w_col_end) r_col <= r_col + IW'(1);
                end
                ST_STORE: begin
                    r_mask <= r_mask + MAX_ORDER'(1);
                    r_rank <= NW'($countones(r_mask + MAX_ORDER'(1)));
                    r_col  <= '0;
                    r_pos  <= '0;
                end
                ST_OUT: if (i_out_ready) r_cnt <= '0;
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_ready_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid) else $error("ready while result held");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= LW'(MAX_ORDER*MAX_ORDER)) else $error("load count overrun");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid) else $error("result dropped");
    a_pipe_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_STORE |-> r_pipe == '0) else $error("store before drain");
`endif
endmodule

// ===== sv/integer_matrix_determinant.sv =====
// Top level of the integer matrix determinant block.
// Depends on imd_pkg, imd_if, imd_ctrl, imd_datapath, imd_ram.
//
//  channel   dir   payload                       handshake
//  in        sink  element[7:1], last[0]         valid/ready
//  out       src   determinant[63:0]             valid/ready
//  cfg       APB   matrix_order @ 0x0            psel/penable/pwrite
//
// Elements load one per cycle while the block is in its load state. After
// the request with last, subsets of columns are walked in order: for each
// subset, terms are issued over its columns, the multiply pipeline drains
// and the sum is stored. The single multiplier and the two memory read
// ports set the pace of this walk. Reset is synchronous, active low; no
// clearing pass. The result is held until taken; input stays stalled meanwhile.
module integer_matrix_determinant #(
    parameter int unsigned MAX_ORDER     = 8,
    parameter int unsigned ELEMENT_WIDTH = 7
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    imd_if.sink                        in_if,
    imd_if.source                      out_if,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [0:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import imd_pkg::*;

    localparam int unsigned CW = $clog2(MAX_ORDER*MAX_ORDER);

    logic [ORDER_W-1:0]   r_order;
    t_cmd                 w_cmd;
    logic                 w_mat_we;
    logic [CW-1:0]        w_mat_waddr;
    logic [CW-1:0]        w_mat_raddr;
    logic [MAX_ORDER-1:0] w_sub_raddr;
    logic [MAX_ORDER-1:0] w_sub_waddr;
    logic                 w_negate;
    logic [DET_W-1:0]     w_acc;
    logic [DET_W-1:0]     r_det;

    // configuration register
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= ORDER_W'(1);
        end else if (psel && penable && pwrite && paddr == REG_MATRIX_ORDER) begin
            r_order <= pwdata[ORDER_W-1:0];
        end
    end
    assign prdata = (paddr == REG_MATRIX_ORDER) ? 32'(r_order) : '0;

    imd_ctrl #(.MAX_ORDER(MAX_ORDER)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_order    (r_order),
        .i_in_valid (in_if.valid),
        .i_in_last  (in_if.data[0]),
        .o_in_ready (in_if.ready),
        .o_out_valid(out_if.valid),
        .i_out_ready(out_if.ready),
        .o_cmd      (w_cmd),
        .o_mat_we   (w_mat_we),
        .o_mat_waddr(w_mat_waddr),
        .o_mat_raddr(w_mat_raddr),
        .o_sub_raddr(w_sub_raddr),
        .o_sub_waddr(w_sub_waddr),
        .o_negate   (w_negate)
    );

    imd_datapath #(.MAX_ORDER(MAX_ORDER), .ELEMENT_WIDTH(ELEMENT_WIDTH)) u_dp (
        .i_clk      (i_clk),
        .i_cmd      (w_cmd),
        .i_mat_we   (w_mat_we),
        .i_mat_waddr(w_mat_waddr),
        .i_mat_wdata(in_if.data[ELEMENT_WIDTH:1]),
        .i_mat_raddr(w_mat_raddr),
        .i_sub_raddr(w_sub_raddr),
        .i_sub_waddr(w_sub_waddr),
        .i_negate   (w_negate),
        .o_acc      (w_acc)
    );

    // last store wrote the full-set sum; accumulator is cleared then, so keep it
    always_ff @(posedge i_clk) begin
        if (w_cmd.store) begin
            r_det <= w_acc;
        end
    end
    assign out_if.data = r_det;
endmodule
